// ===== rtl/core/rslv_pkg.sv =====
// shared types, constants and the arctangent table of the resolver angle block
`timescale 1ns / 1ps
`default_nettype none
package rslv_pkg;

   // converter code and normalisation widths
   localparam int ADC_BITS   = 12;
   localparam int CNT_W      = ADC_BITS + 1;
   localparam int DIFF_W     = CNT_W + 5;
   localparam int GAIN_W     = 18;
   localparam int PROD_W     = DIFF_W + GAIN_W + 1;
   localparam int GAIN_SHIFT = 18;
   localparam int SHIFT_W    = PROD_W - GAIN_SHIFT;
   localparam int NORM_W     = 16;
   localparam int BIAS_W     = 16;
   localparam int OFFSET_W   = 16;
   localparam int ANGLE_W    = 17;
   localparam int CSR_DATA_W = 18;
   localparam int CSR_IDX_W  = 3;

   // cordic datapath widths
   localparam int GUARD_BITS = 8;
   localparam int XY_W       = 27;
   localparam int Z_W        = 28;
   localparam int ANGLE_DROP = 11;
   localparam int MAX_STAGES = 24;

   localparam logic [CNT_W-1:0]  CODE_MID   = CNT_W'(1) << (ADC_BITS - 1);
   localparam logic [Z_W-1:0]    PI_Z       = Z_W'(52707179);
   localparam logic [Z_W-1:0]    ROUND_HALF = Z_W'(1) << (ANGLE_DROP - 1);
   localparam logic [GAIN_W-1:0] GAIN_UNITY = GAIN_W'(131072);

   // atan(2^-i) in radians at 2^-24 resolution, rounded to nearest
   localparam logic [Z_W-1:0] ATAN_TAB [MAX_STAGES] = '{
      Z_W'(13176795), Z_W'(7778716), Z_W'(4110060), Z_W'(2086331),
      Z_W'(1047214),  Z_W'(524117),  Z_W'(262123),  Z_W'(131069),
      Z_W'(65536),    Z_W'(32768),   Z_W'(16384),   Z_W'(8192),
      Z_W'(4096),     Z_W'(2048),    Z_W'(1024),    Z_W'(512),
      Z_W'(256),      Z_W'(128),     Z_W'(64),      Z_W'(32),
      Z_W'(16),       Z_W'(8),       Z_W'(4),       Z_W'(2)
   };

   // register indexes
   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_SINE_BIAS    = 3'd0,
      CSR_COSINE_BIAS  = 3'd1,
      CSR_SINE_GAIN    = 3'd2,
      CSR_COSINE_GAIN  = 3'd3,
      CSR_ANGLE_OFFSET = 3'd4
   } csr_index_type;

   typedef struct packed {
      logic [BIAS_W-1:0]   sine_bias;
      logic [BIAS_W-1:0]   cosine_bias;
      logic [GAIN_W-1:0]   sine_gain;
      logic [GAIN_W-1:0]   cosine_gain;
      logic [OFFSET_W-1:0] angle_offset;
   } csr_type;

   // what one cell hands to the next
   typedef struct packed {
      logic [XY_W-1:0]   x;
      logic [XY_W-1:0]   y;
      logic [Z_W-1:0]    z;
      logic              zero;
      logic [NORM_W-1:0] sine_norm;
      logic [NORM_W-1:0] cosine_norm;
   } cordic_type;

endpackage
`default_nettype wire

// ===== rtl/core/rslv_req_if.sv =====
// request channel carrying one pair of converter codes
`timescale 1ns / 1ps
`default_nettype none
interface rslv_req_if;
   logic                         valid;
   logic                         ready;
   logic [rslv_pkg::ADC_BITS-1:0] sine_code;
   logic [rslv_pkg::ADC_BITS-1:0] cosine_code;

   modport source (output valid, output sine_code, output cosine_code, input ready);
   modport sink   (input valid, input sine_code, input cosine_code, output ready);
endinterface
`default_nettype wire

// ===== rtl/core/rslv_rsp_if.sv =====
// response channel carrying the angle and the normalised sine and cosine
`timescale 1ns / 1ps
`default_nettype none
interface rslv_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [rslv_pkg::ANGLE_W-1:0]  angle;
   logic [rslv_pkg::NORM_W-1:0]   sine_norm;
   logic [rslv_pkg::NORM_W-1:0]   cosine_norm;

   modport source (output valid, output angle, output sine_norm, output cosine_norm,
                   input ready);
   modport sink   (input valid, input angle, input sine_norm, input cosine_norm,
                   output ready);
endinterface
`default_nettype wire

// ===== rtl/core/rslv_front.sv =====
// front end: code to count, bias, gain, saturation and cordic pre-rotation
`timescale 1ns / 1ps
`default_nettype none
module rslv_front (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          in_valid,
   output logic                          in_ready,
   input  logic [rslv_pkg::ADC_BITS-1:0] sine_code,
   input  logic [rslv_pkg::ADC_BITS-1:0] cosine_code,
   input  rslv_pkg::csr_type             csr,
   output logic                          out_valid,
   input  logic                          out_ready,
   output rslv_pkg::cordic_type          out_data
);

   localparam int DIFF_W  = rslv_pkg::DIFF_W;
   localparam int PROD_W  = rslv_pkg::PROD_W;
   localparam int SHIFT_W = rslv_pkg::SHIFT_W;
   localparam int NORM_W  = rslv_pkg::NORM_W;
   localparam int CNT_W   = rslv_pkg::CNT_W;
   localparam int XY_W    = rslv_pkg::XY_W;
   localparam int Z_W     = rslv_pkg::Z_W;
   localparam int GW      = rslv_pkg::GUARD_BITS;

   logic [3:0] valid_ff, valid_in, stage_ready;

   logic signed [DIFF_W-1:0] sdiff_ff, cdiff_ff, sdiff_in, cdiff_in;
   logic signed [PROD_W-1:0] sprod_ff, cprod_ff, sprod_in, cprod_in;
   logic [NORM_W-1:0]        snorm_ff, cnorm_ff, snorm_in, cnorm_in;
   rslv_pkg::cordic_type     rot_ff, rot_in;

   // count = mid - code, then four fraction bits, then bias
   function automatic logic signed [DIFF_W-1:0] debias(
      input logic [rslv_pkg::ADC_BITS-1:0] code,
      input logic [rslv_pkg::BIAS_W-1:0]   bias
   );
      logic [CNT_W-1:0] cnt;
      cnt = rslv_pkg::CODE_MID - {1'b0, code};
      return $signed({cnt[CNT_W-1], cnt, 4'b0000})
           - $signed({{(DIFF_W - rslv_pkg::BIAS_W){bias[rslv_pkg::BIAS_W-1]}}, bias});
   endfunction

   // floor shift to q2.14 then clamp
   function automatic logic [NORM_W-1:0] saturate(input logic signed [PROD_W-1:0] p);
      logic signed [SHIFT_W-1:0] sh;
      sh = SHIFT_W'(p >>> rslv_pkg::GAIN_SHIFT);
      if (sh > $signed(SHIFT_W'({1'b0, {(NORM_W-1){1'b1}}}))) begin
         return {1'b0, {(NORM_W-1){1'b1}}};
      end else if (sh < $signed({{(SHIFT_W-NORM_W+1){1'b1}}, {(NORM_W-1){1'b0}}})) begin
         return {1'b1, {(NORM_W-1){1'b0}}};
      end else begin
         return sh[NORM_W-1:0];
      end
   endfunction

   // a stage moves when empty or when its successor moves
   always_comb begin
      stage_ready[3] = !valid_ff[3] || out_ready;
      stage_ready[2] = !valid_ff[2] || stage_ready[3];
      stage_ready[1] = !valid_ff[1] || stage_ready[2];
      stage_ready[0] = !valid_ff[0] || stage_ready[1];
      valid_in = {valid_ff[2:0], in_valid};
   end

   always_comb begin
      logic        neg;
      logic [16:0] xs, ys;
      sdiff_in = debias(sine_code, csr.sine_bias);
      cdiff_in = debias(cosine_code, csr.cosine_bias);
      sprod_in = sdiff_ff * $signed({1'b0, csr.sine_gain});
      cprod_in = cdiff_ff * $signed({1'b0, csr.cosine_gain});
      snorm_in = saturate(sprod_ff);
      cnorm_in = saturate(cprod_ff);

      // left half plane: turn the vector by pi first
      neg = cnorm_ff[NORM_W-1];
      xs  = {cnorm_ff[NORM_W-1], cnorm_ff};
      ys  = {snorm_ff[NORM_W-1], snorm_ff};
      if (neg) begin
         xs = 17'(-$signed(xs));
         ys = 17'(-$signed(ys));
      end
      rot_in.x = {{(XY_W-17-GW){xs[16]}}, xs, {GW{1'b0}}};
      rot_in.y = {{(XY_W-17-GW){ys[16]}}, ys, {GW{1'b0}}};
      if (!neg) begin
         rot_in.z = '0;
      end else if (!snorm_ff[NORM_W-1]) begin
         rot_in.z = rslv_pkg::PI_Z;
      end else begin
         rot_in.z = Z_W'(-$signed(rslv_pkg::PI_Z));
      end
      rot_in.zero        = (snorm_ff == '0) && (cnorm_ff == '0);
      rot_in.sine_norm   = snorm_ff;
      rot_in.cosine_norm = cnorm_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         for (int k = 0; k < 4; k++) begin
            if (stage_ready[k]) begin
               valid_ff[k] <= valid_in[k];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (stage_ready[0] && valid_in[0]) begin
         sdiff_ff <= sdiff_in;
         cdiff_ff <= cdiff_in;
      end
      if (stage_ready[1] && valid_in[1]) begin
         sprod_ff <= sprod_in;
         cprod_ff <= cprod_in;
      end
      if (stage_ready[2] && valid_in[2]) begin
         snorm_ff <= snorm_in;
         cnorm_ff <= cnorm_in;
      end
      if (stage_ready[3] && valid_in[3]) begin
         rot_ff <= rot_in;
      end
   end

   assign in_ready  = stage_ready[0];
   assign out_valid = valid_ff[3];
   assign out_data  = rot_ff;

endmodule
`default_nettype wire

// ===== rtl/core/rslv_cordic_cell.sv =====
// one vectoring cordic micro-rotation with its own item register
`timescale 1ns / 1ps
`default_nettype none
module rslv_cordic_cell #(
   parameter int STAGE = 0
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 in_valid,
   output logic                 in_ready,
   input  rslv_pkg::cordic_type in_data,
   output logic                 out_valid,
   input  logic                 out_ready,
   output rslv_pkg::cordic_type out_data
);

   logic                 valid_ff;
   logic                 ready;
   rslv_pkg::cordic_type data_ff, data_in;

   assign ready = !valid_ff || out_ready;

   always_comb begin
      logic signed [rslv_pkg::XY_W-1:0] xs, ys;
      xs = $signed(in_data.x) >>> STAGE;
      ys = $signed(in_data.y) >>> STAGE;
      data_in = in_data;
      // drive y towards zero
      if (!in_data.y[rslv_pkg::XY_W-1]) begin
         data_in.x = in_data.x + ys;
         data_in.y = in_data.y - xs;
         data_in.z = in_data.z + rslv_pkg::ATAN_TAB[STAGE];
      end else begin
         data_in.x = in_data.x - ys;
         data_in.y = in_data.y + xs;
         data_in.z = in_data.z - rslv_pkg::ATAN_TAB[STAGE];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (ready) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (ready && in_valid) begin
         data_ff <= data_in;
      end
   end

   assign in_ready  = ready;
   assign out_valid = valid_ff;
   assign out_data  = data_ff;

endmodule
`default_nettype wire

// ===== rtl/core/resolver_angle_from_adc.sv =====
// top level of the resolver angle block: registers, front end, cordic chain, output
`timescale 1ns / 1ps
`default_nettype none
// resolver angle from a pair of complementary-binary converter codes. each request item
// carries a sine and a cosine code; each code becomes the count 2048 - code, the channel
// bias (counts with four fraction bits) is taken off, the channel gain is applied and the
// result is shifted down 18 bits and clamped to q2.14. a vectoring cordic of CORDIC_STAGES
// cells then gives atan2(sine, cosine) in q3.13 radians (-pi..pi), and angle_offset is
// subtracted without wrap. a zero vector gives an arctangent of zero. every request gives
// exactly one response item with the angle and the two normalised values. items enter
// one per clock unless the response stalls and pass four front-end stages (bias, multiply,
// clamp, pre-rotation), one cell per cordic stage and the output register. the chain of
// cells is fully unrolled, each cell holding one item, so items stream through with no
// feedback; a stalled response only holds the full stages, and bubbles further up still
// close. the user must write the registers through the csr port while no item is in flight;
// the block does not enforce it. writes to unused indexes are dropped. no clearing pass.
module resolver_angle_from_adc #(
   parameter int CORDIC_STAGES = 16
) (
   input  logic                                clock,
   input  logic                                reset,
   rslv_req_if.sink                            req_chan,
   rslv_rsp_if.source                          rsp_chan,
   input  logic                                csr_write_enable,
   input  logic [rslv_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [rslv_pkg::CSR_DATA_W-1:0]     csr_write_data
);

   localparam int Z_W     = rslv_pkg::Z_W;
   localparam int ANGLE_W = rslv_pkg::ANGLE_W;
   localparam int DROP    = rslv_pkg::ANGLE_DROP;
   localparam int OFF_W   = rslv_pkg::OFFSET_W;

   // configuration registers
   rslv_pkg::csr_type csr_ff, csr_in;

   always_comb begin
      csr_in = csr_ff;
      if (csr_write_enable) begin
         case (rslv_pkg::csr_index_type'(csr_index))
            rslv_pkg::CSR_SINE_BIAS:    csr_in.sine_bias    = csr_write_data[15:0];
            rslv_pkg::CSR_COSINE_BIAS:  csr_in.cosine_bias  = csr_write_data[15:0];
            rslv_pkg::CSR_SINE_GAIN:    csr_in.sine_gain    = csr_write_data;
            rslv_pkg::CSR_COSINE_GAIN:  csr_in.cosine_gain  = csr_write_data;
            rslv_pkg::CSR_ANGLE_OFFSET: csr_in.angle_offset = csr_write_data[15:0];
            default: ; // unused index, write dropped
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         csr_ff.sine_bias    <= '0;
         csr_ff.cosine_bias  <= '0;
         csr_ff.sine_gain    <= rslv_pkg::GAIN_UNITY;
         csr_ff.cosine_gain  <= rslv_pkg::GAIN_UNITY;
         csr_ff.angle_offset <= '0;
      end else begin
         csr_ff <= csr_in;
      end
   end

   // chain links: index 0 is the front end output, the last one feeds the output register
   rslv_pkg::cordic_type chain_data  [CORDIC_STAGES+1];
   logic                 chain_valid [CORDIC_STAGES+1];
   logic                 chain_ready [CORDIC_STAGES+1];

   rslv_front u_front (
      .clock       (clock),
      .reset       (reset),
      .in_valid    (req_chan.valid),
      .in_ready    (req_chan.ready),
      .sine_code   (req_chan.sine_code),
      .cosine_code (req_chan.cosine_code),
      .csr         (csr_ff),
      .out_valid   (chain_valid[0]),
      .out_ready   (chain_ready[0]),
      .out_data    (chain_data[0])
   );

   // one micro-rotation per cell
   for (genvar g = 0; g < CORDIC_STAGES; g++) begin : g_cell
      rslv_cordic_cell #(.STAGE(g)) u_cell (
         .clock     (clock),
         .reset     (reset),
         .in_valid  (chain_valid[g]),
         .in_ready  (chain_ready[g]),
         .in_data   (chain_data[g]),
         .out_valid (chain_valid[g+1]),
         .out_ready (chain_ready[g+1]),
         .out_data  (chain_data[g+1])
      );
   end

   // output register: round the angle to q3.13 and take off the offset
   logic                      rsp_valid_ff;
   logic                      out_ready;
   logic [ANGLE_W-1:0]        angle_ff, angle_in;
   logic [rslv_pkg::NORM_W-1:0] sine_ff, cosine_ff;

   rslv_pkg::cordic_type last;
   assign last = chain_data[CORDIC_STAGES];

   always_comb begin
      logic [Z_W-1:0]     z_round;
      logic [ANGLE_W:0]   atan_ext;
      logic [ANGLE_W:0]   diff;
      z_round  = last.z + rslv_pkg::ROUND_HALF;
      atan_ext = last.zero ? '0 : (ANGLE_W+1)'($signed(z_round) >>> DROP);
      diff     = atan_ext - {{(ANGLE_W+1-OFF_W){csr_ff.angle_offset[OFF_W-1]}},
                             csr_ff.angle_offset};
      angle_in = diff[ANGLE_W-1:0];
   end

   assign out_ready = !rsp_valid_ff || rsp_chan.ready;
   assign chain_ready[CORDIC_STAGES] = out_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_ready) begin
         rsp_valid_ff <= chain_valid[CORDIC_STAGES];
      end
   end

   always_ff @(posedge clock) begin
      if (out_ready && chain_valid[CORDIC_STAGES]) begin
         angle_ff  <= angle_in;
         sine_ff   <= last.sine_norm;
         cosine_ff <= last.cosine_norm;
      end
   end

   assign rsp_chan.valid       = rsp_valid_ff;
   assign rsp_chan.angle       = angle_ff;
   assign rsp_chan.sine_norm   = sine_ff;
   assign rsp_chan.cosine_norm = cosine_ff;

endmodule
`default_nettype wire

// ===== rtl/core/rslv_checker.sv =====
// port-level checks on the resolver angle block, bound to its top level
`timescale 1ns / 1ps
`default_nettype none
module rslv_checker #(
   parameter int CORDIC_STAGES = 16
) (
   input logic clock,
   input logic reset,
   input logic req_valid,
   input logic req_ready,
   input logic rsp_valid,
   input logic rsp_ready
);

   // each front-end stage, each cell and the output register hold one item
   localparam int DEPTH = CORDIC_STAGES + 5;
   localparam int CNT_W = $clog2(DEPTH + 1) + 1;

   logic [CNT_W-1:0] inflight_ff, inflight_in;

   always_comb begin
      inflight_in = inflight_ff;
      if (req_valid && req_ready) begin
         inflight_in = inflight_in + CNT_W'(1);
      end
      if (rsp_valid && rsp_ready) begin
         inflight_in = inflight_in - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         inflight_ff <= '0;
      end else begin
         inflight_ff <= inflight_in;
      end
   end

   // a response item waits until taken
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("response item dropped while stalled");

   // reset empties the output
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid after reset");

   // no response without an item in flight
   a_no_invent: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> inflight_ff != '0)
      else $error("response item with nothing in flight");

   // an empty pipeline takes a request
   a_empty_ready: assert property (@(posedge clock) disable iff (reset)
      inflight_ff == '0 |-> req_ready)
      else $error("empty block not ready");

   // never more items than storage stages
   a_depth: assert property (@(posedge clock) disable iff (reset)
      inflight_ff <= CNT_W'(DEPTH))
      else $error("more items in flight than stages");

endmodule

bind resolver_angle_from_adc rslv_checker #(.CORDIC_STAGES(CORDIC_STAGES)) u_rslv_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_chan.valid),
   .req_ready (req_chan.ready),
   .rsp_valid (rsp_chan.valid),
   .rsp_ready (rsp_chan.ready)
);
`default_nettype wire

// ===== tb/sv/tb_resolver_angle_from_adc.sv =====
// self-checking bench for the resolver angle block: table rows, then random pairs per setting
`timescale 1ns / 1ps
module tb_resolver_angle_from_adc;
   import rslv_pkg::*;

   // bench configuration
   localparam int     STAGES          = 16;
   localparam int     LATENCY         = STAGES + 5;
   localparam int     PHASES          = 12;
   localparam int     ITEMS_PER_PHASE = 157;
   localparam int     TIMEOUT_CYCLES  = 400000;
   localparam int     MID_CODE        = 1 << (ADC_BITS - 1);
   localparam int     FULL_CODE       = (1 << ADC_BITS) - 1;
   localparam int     NORM_DROP       = 18;
   localparam int     Z_DROP          = 11;
   localparam longint GUARD_SCALE     = 256;
   localparam longint Q24_PI          = 52707179;
   localparam logic [GAIN_W-1:0] UNITY_GAIN = GAIN_W'(131072);

   // atan(2^-i) at 2^-24 rad, rounded to nearest
   localparam longint ARCTAN_Q24 [24] = '{
      13176795, 7778716, 4110060, 2086331, 1047214, 524117, 262123, 131069,
      65536, 32768, 16384, 8192, 4096, 2048, 1024, 512,
      256, 128, 64, 32, 16, 8, 4, 2
   };

   typedef struct packed {
      logic signed [ANGLE_W-1:0] angle;
      logic signed [NORM_W-1:0]  sine_norm;
      logic signed [NORM_W-1:0]  cosine_norm;
   } resolver_result_type;

   // one row of the opening table; typed values replace the prediction where flagged
   typedef struct packed {
      logic [ADC_BITS-1:0]       sine_code;
      logic [ADC_BITS-1:0]       cosine_code;
      logic                      fix_norm;
      logic                      fix_angle;
      logic signed [ANGLE_W-1:0] angle;
      logic signed [NORM_W-1:0]  sine_norm;
      logic signed [NORM_W-1:0]  cosine_norm;
   } probe_row_type;

   // at reset settings a count c normalises to c * 8, so norms read straight off the code
   localparam probe_row_type PROBE_ROWS [20] = '{
      // zero vector: arctangent forced to zero
      '{12'd2048, 12'd2048, 1'b1, 1'b1, 17'sd0, 16'sd0,      16'sd0},
      '{12'd2048, 12'd0,    1'b1, 1'b0, 17'sd0, 16'sd0,      16'sd16384},
      '{12'd0,    12'd2048, 1'b1, 1'b0, 17'sd0, 16'sd16384,  16'sd0},
      // negative cosine with sine zero, accumulator starts at +pi
      '{12'd2048, 12'd4095, 1'b1, 1'b0, 17'sd0, 16'sd0,      -16'sd16376},
      '{12'd4095, 12'd2048, 1'b1, 1'b0, 17'sd0, -16'sd16376, 16'sd0},
      '{12'd0,    12'd0,    1'b1, 1'b0, 17'sd0, 16'sd16384,  16'sd16384},
      '{12'd0,    12'd4095, 1'b1, 1'b0, 17'sd0, 16'sd16384,  -16'sd16376},
      // negative cosine with negative sine, accumulator starts at -pi
      '{12'd4095, 12'd4095, 1'b1, 1'b0, 17'sd0, -16'sd16376, -16'sd16376},
      '{12'd4095, 12'd0,    1'b1, 1'b0, 17'sd0, -16'sd16376, 16'sd16384},
      '{12'd2049, 12'd4095, 1'b1, 1'b0, 17'sd0, -16'sd8,     -16'sd16376},
      '{12'd2047, 12'd4095, 1'b1, 1'b0, 17'sd0, 16'sd8,      -16'sd16376},
      '{12'hAAA,  12'h555,  1'b1, 1'b0, 17'sd0, -16'sd5456,  16'sd5464},
      '{12'h555,  12'hAAA,  1'b1, 1'b0, 17'sd0, 16'sd5464,   -16'sd5456},
      '{12'd2048, 12'd2049, 1'b1, 1'b0, 17'sd0, 16'sd0,      -16'sd8},
      '{12'd2049, 12'd2048, 1'b1, 1'b0, 17'sd0, -16'sd8,     16'sd0},
      '{12'd2047, 12'd2047, 1'b1, 1'b0, 17'sd0, 16'sd8,      16'sd8},
      '{12'd4095, 12'd2047, 1'b1, 1'b0, 17'sd0, -16'sd16376, 16'sd8},
      '{12'd0,    12'd2049, 1'b1, 1'b0, 17'sd0, 16'sd16384,  -16'sd8},
      '{12'd1,    12'd4094, 1'b1, 1'b0, 17'sd0, 16'sd16376,  -16'sd16368},
      '{12'd4094, 12'd1,    1'b1, 1'b0, 17'sd0, -16'sd16368, 16'sd16376}
   };

   logic clock = 1'b0;
   logic reset;
   logic                  csr_write_enable;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_write_data;

   rslv_req_if req_bus ();
   rslv_rsp_if rsp_bus ();

   resolver_angle_from_adc #(
      .CORDIC_STAGES (STAGES)
   ) i_dut (
      .clock            (clock),
      .reset            (reset),
      .req_chan         (req_bus),
      .rsp_chan         (rsp_bus),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data)
   );

   // bench copy of the register file, kept in step with every csr write
   logic signed [BIAS_W-1:0]   cfg_sine_bias;
   logic signed [BIAS_W-1:0]   cfg_cosine_bias;
   logic [GAIN_W-1:0]          cfg_sine_gain;
   logic [GAIN_W-1:0]          cfg_cosine_gain;
   logic signed [OFFSET_W-1:0] cfg_angle_offset;

   resolver_result_type pending_results [$];
   resolver_result_type head_result;
   int cycle_count    = 0;
   int mismatch_count = 0;
   int checked_count  = 0;
   int pairs_sent     = 0;
   int settings_count = 1;
   int tx_calm_left   = 0;
   int rx_calm_left   = 0;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // ---------------------------------------------------------------- predictor

   // code to signed count, bias off, gain on, floor shift down to q2.14, clamp
   function automatic longint norm_channel(input logic [ADC_BITS-1:0] code,
                                           input logic signed [BIAS_W-1:0] bias,
                                           input logic [GAIN_W-1:0] gain);
      longint count;
      longint scaled;
      count  = longint'(MID_CODE) - longint'(code);
      scaled = ((count * 16 - longint'(bias)) * longint'(gain)) >>> NORM_DROP;
      if (scaled > 32767)
         scaled = 32767;
      if (scaled < -32768)
         scaled = -32768;
      return scaled;
   endfunction

   // vectoring cordic on guard-scaled q2.14, angle kept at 2^-24 rad
   function automatic longint cordic_atan2(input longint y_in, input longint x_in);
      longint x;
      longint y;
      longint z;
      longint t;
      x = x_in;
      y = y_in;
      z = 0;
      if (x == 0 && y == 0)
         return 0;
      // left half plane: rotate by pi first, sign of pi follows the sine
      if (x < 0) begin
         z = (y >= 0) ? Q24_PI : -Q24_PI;
         x = -x;
         y = -y;
      end
      x = x * GUARD_SCALE;
      y = y * GUARD_SCALE;
      for (int i = 0; i < STAGES; i++) begin
         if (y >= 0) begin
            t = x + (y >>> i);
            y = y - (x >>> i);
            z = z + ARCTAN_Q24[i];
         end else begin
            t = x - (y >>> i);
            y = y + (x >>> i);
            z = z - ARCTAN_Q24[i];
         end
         x = t;
      end
      // round half up into q3.13
      return (z + (longint'(1) << (Z_DROP - 1))) >>> Z_DROP;
   endfunction

   function automatic resolver_result_type predict_resolver(
      input logic [ADC_BITS-1:0] s_code,
      input logic [ADC_BITS-1:0] c_code);
      resolver_result_type r;
      longint s;
      longint c;
      longint a;
      s = norm_channel(s_code, cfg_sine_bias, cfg_sine_gain);
      c = norm_channel(c_code, cfg_cosine_bias, cfg_cosine_gain);
      // offset comes off with no wrap; 17 bits hold every outcome
      a = cordic_atan2(s, c) - longint'(cfg_angle_offset);
      r.angle       = a[ANGLE_W-1:0];
      r.sine_norm   = s[NORM_W-1:0];
      r.cosine_norm = c[NORM_W-1:0];
      return r;
   endfunction

   // ---------------------------------------------------------------- stimulus helpers

   // per-item wait, with the odd stretch of back-to-back items
   function automatic int draw_wait(ref int calm_left);
      if (calm_left > 0) begin
         calm_left--;
         return 0;
      end
      if ($urandom_range(0, 15) == 0) begin
         calm_left = $urandom_range(20, 60);
         return 0;
      end
      return $urandom_range(0, 15);
   endfunction

   function automatic logic [ADC_BITS-1:0] pick_code(input bit near_mid);
      if (near_mid)
         return ADC_BITS'(MID_CODE + $urandom_range(0, 64) - 32);
      case ($urandom_range(0, 9))
         0: return $urandom_range(0, 1) ? ADC_BITS'(0) : ADC_BITS'(FULL_CODE);
         1: return ADC_BITS'($urandom_range(0, 15));
         2: return ADC_BITS'(FULL_CODE - $urandom_range(0, 15));
         3: return ADC_BITS'(MID_CODE + $urandom_range(0, 256) - 128);
         default: return ADC_BITS'($urandom);
      endcase
   endfunction

   // one register write per falling edge; enable left high for back-to-back writes
   task automatic write_csr(input logic [CSR_IDX_W-1:0] idx, input logic [CSR_DATA_W-1:0] data);
      csr_write_enable = 1'b1;
      csr_index        = idx;
      csr_write_data   = data;
      case (idx)
         CSR_SINE_BIAS:    cfg_sine_bias    = data[BIAS_W-1:0];
         CSR_COSINE_BIAS:  cfg_cosine_bias  = data[BIAS_W-1:0];
         CSR_SINE_GAIN:    cfg_sine_gain    = data[GAIN_W-1:0];
         CSR_COSINE_GAIN:  cfg_cosine_gain  = data[GAIN_W-1:0];
         CSR_ANGLE_OFFSET: cfg_angle_offset = data[OFFSET_W-1:0];
         default: ;  // unused index: dropped
      endcase
      @(negedge clock);
   endtask

   function automatic logic [GAIN_W-1:0] pick_gain();
      case ($urandom_range(0, 4))
         3: return GAIN_W'($urandom);
         4: return UNITY_GAIN + GAIN_W'($urandom_range(0, 4096));
         default: return GAIN_W'($urandom_range(100000, 262143));
      endcase
   endfunction

   function automatic logic [BIAS_W-1:0] pick_bias();
      case ($urandom_range(0, 3))
         0: return '0;
         1: return BIAS_W'($urandom_range(0, 1023) - 512);
         default: return BIAS_W'($urandom);
      endcase
   endfunction

   // register settings: a few fixed extremes first, random ones after
   task automatic apply_setting(input int phase);
      logic [BIAS_W-1:0]   sb;
      logic [BIAS_W-1:0]   cb;
      logic [GAIN_W-1:0]   sg;
      logic [GAIN_W-1:0]   cg;
      logic [OFFSET_W-1:0] off;
      case (phase)
         1: begin  // full-scale gains, largest legal offset
            sb = '0;  cb = '0;  sg = '1;  cg = '1;
            off = OFFSET_W'(25736);
         end
         2: begin  // both gains zero: every pair is a zero vector
            sb = pick_bias();  cb = pick_bias();  sg = '0;  cg = '0;
            off = OFFSET_W'(-25736);
         end
         3: begin  // sine gain zero, bias extremes
            sb = 16'h7FFF;  cb = 16'h8000;  sg = '0;  cg = UNITY_GAIN;
            off = '0;
         end
         4: begin  // saturation both ways, offset below its range
            sb = 16'h8000;  cb = 16'h7FFF;  sg = '1;  cg = '1;
            off = 16'h8000;
         end
         5: begin  // small biases, offset above its range
            sb = BIAS_W'($urandom_range(0, 63) - 32);
            cb = BIAS_W'($urandom_range(0, 63) - 32);
            sg = UNITY_GAIN;  cg = UNITY_GAIN;
            off = 16'h7FFF;
         end
         default: begin
            sb = pick_bias();  cb = pick_bias();  sg = pick_gain();  cg = pick_gain();
            off = ($urandom_range(0, 3) == 0) ? OFFSET_W'($urandom)
                                              : OFFSET_W'($urandom_range(0, 51472) - 25736);
         end
      endcase
      // a write to an unused index must leave everything alone
      write_csr(CSR_IDX_W'(CSR_ANGLE_OFFSET) + CSR_IDX_W'($urandom_range(1, 3)),
                CSR_DATA_W'($urandom));
      // spare upper data bits carry noise on the 16-bit registers
      write_csr(CSR_SINE_BIAS,    {2'($urandom), sb});
      write_csr(CSR_COSINE_BIAS,  {2'($urandom), cb});
      write_csr(CSR_SINE_GAIN,    sg);
      write_csr(CSR_COSINE_GAIN,  cg);
      write_csr(CSR_ANGLE_OFFSET, {2'($urandom), off});
      csr_write_enable = 1'b0;
      settings_count++;
   endtask

   // hold one pair until taken, queue its expected result, then the sender's gap
   task automatic send_pair(input logic [ADC_BITS-1:0] s_code,
                            input logic [ADC_BITS-1:0] c_code,
                            input resolver_result_type want);
      int gap;
      req_bus.valid       = 1'b1;
      req_bus.sine_code   = s_code;
      req_bus.cosine_code = c_code;
      do
         @(posedge clock);
      while (!req_bus.ready);
      pending_results.push_back(want);
      pairs_sent++;
      @(negedge clock);
      gap = draw_wait(tx_calm_left);
      if (gap > 0) begin
         req_bus.valid = 1'b0;
         repeat (gap) @(negedge clock);
      end
   endtask

   // every pair gives a result, so an empty queue means an empty pipeline
   task automatic wait_drained();
      req_bus.valid = 1'b0;
      while (pending_results.size() != 0)
         @(negedge clock);
   endtask

   task automatic log_mismatch(input string what, input longint got, input longint want);
      mismatch_count++;
      $display("mismatch at cycle %0d: %s got %0d expected %0d", cycle_count, what, got,
               want);
   endtask

   // ---------------------------------------------------------------- result side

   // receiver: random stall per item, sometimes long runs with ready held high
   initial begin
      int stall;
      rsp_bus.ready = 1'b0;
      @(negedge clock);
      while (reset)
         @(negedge clock);
      forever begin
         stall = draw_wait(rx_calm_left);
         if (stall > 0) begin
            rsp_bus.ready = 1'b0;
            repeat (stall) @(negedge clock);
         end
         rsp_bus.ready = 1'b1;
         do
            @(posedge clock);
         while (!rsp_bus.valid);
         @(negedge clock);
      end
   end

   // compare every accepted result with the oldest outstanding one
   always @(posedge clock) begin
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         if (pending_results.size() == 0) begin
            log_mismatch("result with nothing outstanding, angle", $signed(rsp_bus.angle), 0);
         end else begin
            head_result = pending_results.pop_front();
            checked_count++;
            if (rsp_bus.angle !== head_result.angle)
               log_mismatch("angle", $signed(rsp_bus.angle), head_result.angle);
            if (rsp_bus.sine_norm !== head_result.sine_norm)
               log_mismatch("sine_norm", $signed(rsp_bus.sine_norm), head_result.sine_norm);
            if (rsp_bus.cosine_norm !== head_result.cosine_norm)
               log_mismatch("cosine_norm", $signed(rsp_bus.cosine_norm),
                            head_result.cosine_norm);
         end
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
   end

   // watchdog
   initial begin
      wait (cycle_count >= TIMEOUT_CYCLES);
      $display("timeout after %0d cycles, %0d results outstanding", cycle_count,
               pending_results.size());
      $display("CHECKS FAILED");
      $finish;
   end

   // ---------------------------------------------------------------- main sequence

   initial begin
      resolver_result_type want;
      logic [ADC_BITS-1:0] s_code;
      logic [ADC_BITS-1:0] c_code;
      bit small_vector;
      req_bus.valid       = 1'b0;
      req_bus.sine_code   = '0;
      req_bus.cosine_code = '0;
      csr_write_enable    = 1'b0;
      csr_index           = '0;
      csr_write_data      = '0;
      cfg_sine_bias       = '0;
      cfg_cosine_bias     = '0;
      cfg_sine_gain       = UNITY_GAIN;
      cfg_cosine_gain     = UNITY_GAIN;
      cfg_angle_offset    = '0;
      reset               = 1'b1;
      repeat (6) @(negedge clock);
      reset = 1'b0;
      @(negedge clock);

      // table at reset settings: extremes, quadrant edges, zero vector
      foreach (PROBE_ROWS[k]) begin
         want = predict_resolver(PROBE_ROWS[k].sine_code, PROBE_ROWS[k].cosine_code);
         if (PROBE_ROWS[k].fix_norm) begin
            want.sine_norm   = PROBE_ROWS[k].sine_norm;
            want.cosine_norm = PROBE_ROWS[k].cosine_norm;
         end
         if (PROBE_ROWS[k].fix_angle)
            want.angle = PROBE_ROWS[k].angle;
         send_pair(PROBE_ROWS[k].sine_code, PROBE_ROWS[k].cosine_code, want);
      end

      // random pairs; settings change only once the pipeline has emptied
      for (int phase = 0; phase < PHASES; phase++) begin
         if (phase > 0) begin
            wait_drained();
            apply_setting(phase);
         end
         repeat (ITEMS_PER_PHASE) begin
            small_vector = ($urandom_range(0, 7) == 0);
            s_code = pick_code(small_vector);
            c_code = pick_code(small_vector);
            send_pair(s_code, c_code, predict_resolver(s_code, c_code));
         end
      end

      wait_drained();
      repeat (LATENCY + 8) @(negedge clock);

      $display("%0d code pairs over %0d register settings, %0d results compared",
               pairs_sent, settings_count, checked_count);
      $display("%0d mismatches, %0d results still outstanding", mismatch_count,
               pending_results.size());
      if (mismatch_count == 0 && pending_results.size() == 0)
         $display("ALL CHECKS PASSED");
      else
         $display("CHECKS FAILED");
      $finish;
   end

endmodule

// ===== filelist.f =====
rtl/core/rslv_pkg.sv
rtl/core/rslv_req_if.sv
rtl/core/rslv_rsp_if.sv
rtl/core/rslv_front.sv
rtl/core/rslv_cordic_cell.sv
rtl/core/resolver_angle_from_adc.sv
rtl/core/rslv_checker.sv
tb/sv/tb_resolver_angle_from_adc.sv
